// ===== rtl/core/uaa_pkg.sv =====
// Shared constants and register index codes for the upwind age row assembly unit.
`timescale 1ns / 1ps

package uaa_pkg;

   localparam int DATA_WIDTH_DEF  = 48;
   localparam int FRAC_BITS_DEF   = 24;
   localparam int MUL_LAT         = 6;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TIME_STEP,
      CSR_INV_DX,
      CSR_INV_DY,
      CSR_DT_OVER_DZ
   } csr_index_type;

endpackage

// ===== rtl/core/uaa_req_if.sv =====
// Input channel carrying one ice level per transaction.
`timescale 1ns / 1ps

interface uaa_req_if #(
   parameter int DATA_WIDTH = uaa_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         is_base;
   logic                         is_surface;
   logic signed [DATA_WIDTH-1:0] vel_x;
   logic signed [DATA_WIDTH-1:0] vel_y;
   logic signed [DATA_WIDTH-1:0] vel_z;
   logic signed [DATA_WIDTH-1:0] age_here;
   logic signed [DATA_WIDTH-1:0] age_north;
   logic signed [DATA_WIDTH-1:0] age_east;
   logic signed [DATA_WIDTH-1:0] age_south;
   logic signed [DATA_WIDTH-1:0] age_west;

   modport source (
      output valid, is_base, is_surface, vel_x, vel_y, vel_z,
             age_here, age_north, age_east, age_south, age_west,
      input  ready
   );

   modport sink (
      input  valid, is_base, is_surface, vel_x, vel_y, vel_z,
             age_here, age_north, age_east, age_south, age_west,
      output ready
   );
endinterface

// ===== rtl/core/uaa_rsp_if.sv =====
// Result channel carrying one tridiagonal row per transaction.
`timescale 1ns / 1ps

interface uaa_rsp_if #(
   parameter int DATA_WIDTH = uaa_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] lower_coef;
   logic signed [DATA_WIDTH-1:0] diag_coef;
   logic signed [DATA_WIDTH-1:0] upper_coef;
   logic signed [DATA_WIDTH-1:0] right_side;

   modport source (
      output valid, lower_coef, diag_coef, upper_coef, right_side,
      input  ready
   );

   modport sink (
      input  valid, lower_coef, diag_coef, upper_coef, right_side,
      output ready
   );
endinterface

// ===== rtl/core/uaa_fx_mul.sv =====
// Pipelined saturating signed fixed-point multiplier with floor rounding.
`timescale 1ns / 1ps

module uaa_fx_mul #(
   parameter int DATA_WIDTH = uaa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = uaa_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [DATA_WIDTH-1:0] op_a,
   input  logic signed [DATA_WIDTH-1:0] op_b,
   output logic signed [DATA_WIDTH-1:0] product
);
   import uaa_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int H  = (DATA_WIDTH + 1) / 2;
   localparam int PW = 4 * H;
   localparam int QW = PW - FRAC_BITS;

   localparam logic [QW:0] MAX_POS = (QW+1)'({(W-1){1'b1}});
   localparam logic [QW:0] MAX_NEG = MAX_POS + (QW+1)'(1);
   localparam logic signed [W-1:0] MAX_FX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN_FX = {1'b1, {(W-1){1'b0}}};

   // stage 1: magnitudes
   logic [W-1:0]   mag_a_in, mag_b_in;
   logic [W-1:0]   mag_a_ff, mag_b_ff;
   logic [4:0]     neg_ff;
   // stage 2: partial products
   logic [2*H-1:0] pad_a, pad_b;
   logic [2*H-1:0] p00_in, p01_in, p10_in, p11_in;
   logic [2*H-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   // stage 3: cross term
   logic [2*H:0]   cross_ff;
   logic [2*H-1:0] p00_s3_ff, p11_s3_ff;
   // stage 4: full product
   logic [PW-1:0]  prod_in, prod_ff;
   // stage 5: floor adjust
   logic [QW:0]    qa_in, qa_ff;
   logic           frac_nz;
   // stage 6: saturate
   logic signed [W-1:0] res_in, res_ff;

   assign mag_a_in = op_a[W-1] ? W'(-op_a) : W'(op_a);
   assign mag_b_in = op_b[W-1] ? W'(-op_b) : W'(op_b);

   assign pad_a  = (2*H)'(mag_a_ff);
   assign pad_b  = (2*H)'(mag_b_ff);
   assign p00_in = pad_a[H-1:0]   * pad_b[H-1:0];
   assign p01_in = pad_a[H-1:0]   * pad_b[2*H-1:H];
   assign p10_in = pad_a[2*H-1:H] * pad_b[H-1:0];
   assign p11_in = pad_a[2*H-1:H] * pad_b[2*H-1:H];

   assign prod_in = {p11_s3_ff, p00_s3_ff} + (PW'(cross_ff) << H);

   assign frac_nz = |prod_ff[FRAC_BITS-1:0];
   assign qa_in   = {1'b0, prod_ff[PW-1:FRAC_BITS]} + (QW+1)'(neg_ff[3] & frac_nz);

   always_comb begin
      if (neg_ff[4]) begin
         res_in = (qa_ff > MAX_NEG) ? MIN_FX : W'(-qa_ff[W-1:0]);
      end else begin
         res_in = (qa_ff > MAX_POS) ? MAX_FX : W'(qa_ff[W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_a_ff  <= mag_a_in;
         mag_b_ff  <= mag_b_in;
         neg_ff    <= {neg_ff[3:0], op_a[W-1] ^ op_b[W-1]};
         p00_ff    <= p00_in;
         p01_ff    <= p01_in;
         p10_ff    <= p10_in;
         p11_ff    <= p11_in;
         cross_ff  <= {1'b0, p01_ff} + {1'b0, p10_ff};
         p00_s3_ff <= p00_ff;
         p11_s3_ff <= p11_ff;
         prod_ff   <= prod_in;
         qa_ff     <= qa_in;
         res_ff    <= res_in;
      end
   end

   assign product = res_ff;

endmodule

// ===== rtl/core/uaa_delay.sv =====
// Enabled delay line that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps

module uaa_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   import uaa_pkg::*;

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// ===== rtl/core/upwind_age_advection_row_assembly_unit.sv =====
// Top level of the upwind age row assembly unit: one ice level in, one tridiagonal
// row out. Accepts one transaction every cycle while the skid entry is empty. The
// right-side path runs through three dependent six-stage multipliers (velocity
// times difference, times inverse spacing, times time step). All arithmetic is
// Q(DATA_WIDTH-FRAC_BITS-1).FRAC_BITS, saturating, products rounded toward minus
// infinity. A two-entry output skid lets req_chan.ready come from a register; the
// whole pipeline holds while the skid entry is occupied. Registers are to be written
// through csr_* only while the unit is idle, which the unit does not enforce;
// unknown indexes are ignored.
`timescale 1ns / 1ps

module upwind_age_advection_row_assembly_unit #(
   parameter int DATA_WIDTH = uaa_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = uaa_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   uaa_req_if.sink                   req_chan,
   uaa_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  uaa_pkg::csr_index_type    csr_index,
   input  logic [DATA_WIDTH-2:0]     csr_wdata
);
   import uaa_pkg::*;

   localparam int W          = DATA_WIDTH;
   localparam int CW         = DATA_WIDTH - 1;
   localparam int PIPE_DEPTH = 3 * MUL_LAT + 5;
   localparam int COEF_W     = 3 * W + 1;

   localparam logic signed [W-1:0] ONE_FX = W'(65'd1 << FRAC_BITS);
   localparam logic signed [W-1:0] MAX_FX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN_FX = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? MIN_FX : MAX_FX;
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? MIN_FX : MAX_FX;
      end
      return s[W-1:0];
   endfunction

   // configuration
   logic [CW-1:0] time_step_ff, inv_dx_ff, inv_dy_ff, dt_over_dz_ff;

   // pipeline control
   logic                  enable;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  out_valid;

   // stage 0: input register
   logic                base0_ff, surf0_ff;
   logic signed [W-1:0] u0_ff, v0_ff, w0_ff;
   logic signed [W-1:0] ah0_ff, an0_ff, ae0_ff, as0_ff, aw0_ff;

   // stage 1: upwind differences
   logic                base1_ff, surf1_ff;
   logic signed [W-1:0] u1_ff, v1_ff, w1_ff, ah1_ff;
   logic signed [W-1:0] dx1_ff, dy1_ff;

   // multiplier outputs
   logic signed [W-1:0] hx_pre, hy_pre, hx, hy, wz, tmul;
   logic [1:0]          flags_d;
   logic [W-1:0]        ah_d;

   // coefficient stage
   logic signed [W-1:0] lo_in, di_in, up_in;
   logic                zr_in;
   logic [COEF_W-1:0]   coef_ff, coef_d;

   // right side path
   logic signed [W-1:0] adv_ff, onem_ff;

   // output register and skid entry
   logic signed [W-1:0] lo_out_ff, di_out_ff, up_out_ff, rhs_out_ff;
   logic                skid_valid_ff;
   logic signed [W-1:0] lo_skid_ff, di_skid_ff, up_skid_ff, rhs_skid_ff;

   assign enable    = !skid_valid_ff;
   assign out_valid = valid_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= CW'(ONE_FX);
         inv_dx_ff     <= CW'(ONE_FX);
         inv_dy_ff     <= CW'(ONE_FX);
         dt_over_dz_ff <= CW'(ONE_FX);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIME_STEP:  time_step_ff  <= csr_wdata;
            CSR_INV_DX:     inv_dx_ff     <= csr_wdata;
            CSR_INV_DY:     inv_dy_ff     <= csr_wdata;
            CSR_DT_OVER_DZ: dt_over_dz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (enable) begin
            valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_chan.valid};
         end
         if (skid_valid_ff) begin
            if (rsp_chan.ready) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (out_valid && !rsp_chan.ready) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff && out_valid && !rsp_chan.ready) begin
         lo_skid_ff  <= lo_out_ff;
         di_skid_ff  <= di_out_ff;
         up_skid_ff  <= up_out_ff;
         rhs_skid_ff <= rhs_out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         base0_ff <= req_chan.is_base;
         surf0_ff <= req_chan.is_surface;
         u0_ff    <= req_chan.vel_x;
         v0_ff    <= req_chan.vel_y;
         w0_ff    <= req_chan.vel_z;
         ah0_ff   <= req_chan.age_here;
         an0_ff   <= req_chan.age_north;
         ae0_ff   <= req_chan.age_east;
         as0_ff   <= req_chan.age_south;
         aw0_ff   <= req_chan.age_west;

         base1_ff <= base0_ff;
         surf1_ff <= surf0_ff;
         u1_ff    <= u0_ff;
         v1_ff    <= v0_ff;
         w1_ff    <= w0_ff;
         ah1_ff   <= ah0_ff;
         dx1_ff   <= u0_ff[W-1] ? sat_sub(ae0_ff, ah0_ff) : sat_sub(ah0_ff, aw0_ff);
         dy1_ff   <= v0_ff[W-1] ? sat_sub(an0_ff, ah0_ff) : sat_sub(ah0_ff, as0_ff);
      end
   end

   uaa_fx_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_ux (
      .clock(clock), .enable(enable), .op_a(u1_ff), .op_b(dx1_ff), .product(hx_pre)
   );

   uaa_fx_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_vy (
      .clock(clock), .enable(enable), .op_a(v1_ff), .op_b(dy1_ff), .product(hy_pre)
   );

   uaa_fx_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_wz (
      .clock(clock), .enable(enable), .op_a({1'b0, dt_over_dz_ff}), .op_b(w1_ff),
      .product(wz)
   );

   uaa_fx_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_dx (
      .clock(clock), .enable(enable), .op_a(hx_pre), .op_b({1'b0, inv_dx_ff}),
      .product(hx)
   );

   uaa_fx_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_dy (
      .clock(clock), .enable(enable), .op_a(hy_pre), .op_b({1'b0, inv_dy_ff}),
      .product(hy)
   );

   uaa_fx_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul_dt (
      .clock(clock), .enable(enable), .op_a({1'b0, time_step_ff}), .op_b(onem_ff),
      .product(tmul)
   );

   uaa_delay #(.WIDTH(2), .DEPTH(MUL_LAT)) u_dly_flags (
      .clock(clock), .enable(enable), .din({surf1_ff, base1_ff}), .dout(flags_d)
   );

   uaa_delay #(.WIDTH(W), .DEPTH(3 * MUL_LAT + 2)) u_dly_age (
      .clock(clock), .enable(enable), .din(ah1_ff), .dout(ah_d)
   );

   // vertical implicit upwind; surface wins over base
   always_comb begin
      lo_in = '0;
      di_in = ONE_FX;
      up_in = '0;
      zr_in = 1'b0;
      if (flags_d[1]) begin
         zr_in = 1'b1;
      end else if (flags_d[0]) begin
         if (!wz[W-1] && (wz != '0)) begin
            zr_in = 1'b1;
         end else begin
            di_in = sat_sub(ONE_FX, wz);
            up_in = wz;
         end
      end else if (!wz[W-1]) begin
         lo_in = sat_sub('0, wz);
         di_in = sat_add(ONE_FX, wz);
      end else begin
         di_in = sat_sub(ONE_FX, wz);
         up_in = wz;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         coef_ff <= {zr_in, lo_in, di_in, up_in};
         adv_ff  <= sat_add(hx, hy);
         onem_ff <= sat_sub(ONE_FX, adv_ff);
      end
   end

   uaa_delay #(.WIDTH(COEF_W), .DEPTH(2 * MUL_LAT + 1)) u_dly_coef (
      .clock(clock), .enable(enable), .din(coef_ff), .dout(coef_d)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_out_ff  <= coef_d[3*W-1:2*W];
         di_out_ff  <= coef_d[2*W-1:W];
         up_out_ff  <= coef_d[W-1:0];
         rhs_out_ff <= coef_d[3*W] ? '0 : sat_add(ah_d, tmul);
      end
   end

   assign req_chan.ready      = enable;
   assign rsp_chan.valid      = skid_valid_ff | out_valid;
   assign rsp_chan.lower_coef = skid_valid_ff ? lo_skid_ff  : lo_out_ff;
   assign rsp_chan.diag_coef  = skid_valid_ff ? di_skid_ff  : di_out_ff;
   assign rsp_chan.upper_coef = skid_valid_ff ? up_skid_ff  : up_out_ff;
   assign rsp_chan.right_side = skid_valid_ff ? rhs_skid_ff : rhs_out_ff;

endmodule

// ===== tb/uaa_row_checker.sv =====
// Checker for the upwind age row assembly unit: predicts every row and compares it.
`timescale 1ns / 1ps

module uaa_row_checker #(
   parameter int DW = uaa_pkg::DATA_WIDTH_DEF,
   parameter int FB = uaa_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   uaa_req_if                     req_mon,
   uaa_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  uaa_pkg::csr_index_type csr_index,
   input  logic [DW-2:0]          csr_wdata,
   output int                     fail_count,
   output int                     rows_checked,
   output int                     rows_pending
);
   import uaa_pkg::*;

   typedef logic signed [DW-1:0]  fx_t;
   typedef logic signed [127:0]   wide_t;
   typedef logic [DW-2:0]         cfg_t;

   typedef struct packed {
      fx_t lower;
      fx_t diag;
      fx_t upper;
      fx_t rhs;
   } row_t;

   localparam fx_t  FX_ONE = fx_t'(64'd1 << FB);
   localparam fx_t  FX_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam fx_t  FX_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam cfg_t CFG_ONE = cfg_t'(64'd1 << FB);

   cfg_t time_step_cfg;
   cfg_t inv_dx_cfg;
   cfg_t inv_dy_cfg;
   cfg_t dt_over_dz_cfg;
   row_t rows_expected[$];

   function automatic fx_t clip(wide_t v);
      wide_t hi_lim;
      wide_t lo_lim;
      hi_lim = FX_MAX;
      lo_lim = FX_MIN;
      if (v > hi_lim) return FX_MAX;
      if (v < lo_lim) return FX_MIN;
      return fx_t'(v);
   endfunction

   function automatic fx_t fx_add(fx_t a, fx_t b);
      wide_t wa;
      wide_t wb;
      wa = a;
      wb = b;
      return clip(wa + wb);
   endfunction

   function automatic fx_t fx_sub(fx_t a, fx_t b);
      wide_t wa;
      wide_t wb;
      wa = a;
      wb = b;
      return clip(wa - wb);
   endfunction

   // exact product, floor shift, then saturate
   function automatic fx_t fx_mul(fx_t a, fx_t b);
      wide_t wa;
      wide_t wb;
      wide_t p;
      wa = a;
      wb = b;
      p  = wa * wb;
      return clip(p >>> FB);
   endfunction

   function automatic fx_t cfg_fx(cfg_t c);
      return fx_t'({1'b0, c});
   endfunction

   function automatic row_t assemble_row(logic base, logic surf, fx_t u, fx_t v, fx_t w,
                                         fx_t ah, fx_t an, fx_t ae, fx_t a_s, fx_t aw);
      row_t r;
      fx_t  hx;
      fx_t  hy;
      fx_t  adv;
      fx_t  vert;
      hx = fx_mul(fx_mul(u, (u < 0) ? fx_sub(ae, ah) : fx_sub(ah, aw)), cfg_fx(inv_dx_cfg));
      hy = fx_mul(fx_mul(v, (v < 0) ? fx_sub(an, ah) : fx_sub(ah, a_s)), cfg_fx(inv_dy_cfg));
      adv   = fx_add(hx, hy);
      r.rhs = fx_add(ah, fx_mul(cfg_fx(time_step_cfg), fx_sub(FX_ONE, adv)));
      vert  = fx_mul(cfg_fx(dt_over_dz_cfg), w);
      r.lower = '0;
      r.upper = '0;
      if (surf) begin
         r.diag = FX_ONE;
         r.rhs  = '0;
      end else if (base) begin
         if (vert > 0) begin
            r.diag = FX_ONE;
            r.rhs  = '0;
         end else begin
            r.diag  = fx_sub(FX_ONE, vert);
            r.upper = vert;
         end
      end else if (vert >= 0) begin
         r.lower = fx_sub(fx_t'(0), vert);
         r.diag  = fx_add(FX_ONE, vert);
      end else begin
         r.diag  = fx_sub(FX_ONE, vert);
         r.upper = vert;
      end
      return r;
   endfunction

   function automatic int compare_field(string name, fx_t want, fx_t got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : row_check
      row_t want;
      int   bad;
      bad = 0;
      if (reset) begin
         time_step_cfg  <= CFG_ONE;
         inv_dx_cfg     <= CFG_ONE;
         inv_dy_cfg     <= CFG_ONE;
         dt_over_dz_cfg <= CFG_ONE;
         rows_expected.delete();
         fail_count   <= 0;
         rows_checked <= 0;
         rows_pending <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            rows_expected.push_back(assemble_row(req_mon.is_base, req_mon.is_surface,
               req_mon.vel_x, req_mon.vel_y, req_mon.vel_z, req_mon.age_here,
               req_mon.age_north, req_mon.age_east, req_mon.age_south, req_mon.age_west));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rows_expected.size() == 0) begin
               $error("row transaction with no row pending");
               bad++;
            end else begin
               want = rows_expected.pop_front();
               bad += compare_field("lower_coef", want.lower, rsp_mon.lower_coef);
               bad += compare_field("diag_coef", want.diag, rsp_mon.diag_coef);
               bad += compare_field("upper_coef", want.upper, rsp_mon.upper_coef);
               bad += compare_field("right_side", want.rhs, rsp_mon.right_side);
               rows_checked <= rows_checked + 1;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TIME_STEP:  time_step_cfg  <= csr_wdata;
               CSR_INV_DX:     inv_dx_cfg     <= csr_wdata;
               CSR_INV_DY:     inv_dy_cfg     <= csr_wdata;
               CSR_DT_OVER_DZ: dt_over_dz_cfg <= csr_wdata;
               default: ;
            endcase
         end
         fail_count   <= fail_count + bad;
         rows_pending <= rows_expected.size();
      end
   end

endmodule

// ===== tb/tb_upwind_age_advection_row_assembly_unit.sv =====
// Testbench top for the upwind age row assembly unit: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_upwind_age_advection_row_assembly_unit;
   import uaa_pkg::*;

   localparam int DW               = DATA_WIDTH_DEF;
   localparam int FB               = FRAC_BITS_DEF;
   localparam int ROW_LATENCY      = 3 * MUL_LAT + 5;
   localparam int TAIL_CYCLES      = ROW_LATENCY + 20;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int NUM_PHASES       = 7;
   localparam int RANDOM_PER_PHASE = 250;

   typedef logic signed [DW-1:0] fx_t;
   typedef logic [DW-2:0]        cfg_t;

   typedef struct packed {
      logic is_base;
      logic is_surface;
      fx_t  vel_x;
      fx_t  vel_y;
      fx_t  vel_z;
      fx_t  age_here;
      fx_t  age_north;
      fx_t  age_east;
      fx_t  age_south;
      fx_t  age_west;
   } level_t;

   localparam fx_t  FX_ONE  = fx_t'(64'd1 << FB);
   localparam fx_t  FX_HALF = FX_ONE >>> 1;
   localparam fx_t  FX_MAX  = {1'b0, {(DW-1){1'b1}}};
   localparam fx_t  FX_MIN  = {1'b1, {(DW-1){1'b0}}};
   localparam cfg_t CFG_MAX = '1;
   localparam cfg_t CFG_ONE = cfg_t'(64'd1 << FB);

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   cfg_t          csr_wdata;
   int            fail_count;
   int            rows_checked;
   int            rows_pending;
   int            levels_sent = 0;
   int            cycle_count = 0;
   int            req_idle_pct = 23;
   int            rsp_stall_pct = 82;

   uaa_req_if #(.DATA_WIDTH(DW)) req_bus ();
   uaa_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

   upwind_age_advection_row_assembly_unit #(
      .DATA_WIDTH(DW),
      .FRAC_BITS (FB)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   uaa_row_checker #(
      .DW(DW),
      .FB(FB)
   ) i_row_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .rows_checked(rows_checked),
      .rows_pending(rows_pending)
   );

   always #5 clock = ~clock;

   initial begin : rsp_ready_gen
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic fx_t rand_fx();
      logic signed [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0:       return FX_MAX;
         1:       return FX_MIN;
         2:       return '0;
         3, 4, 5: return fx_t'(r >>> $urandom_range(0, 8));
         6:       return fx_t'(r >>> 16);
         default: return fx_t'({$urandom, $urandom});
      endcase
   endfunction

   function automatic fx_t near_age(fx_t center);
      logic signed [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 1)) return center + fx_t'(r >>> 8);
      return rand_fx();
   endfunction

   function automatic cfg_t rand_cfg();
      case ($urandom_range(0, 7))
         0:       return CFG_MAX;
         1:       return '0;
         2:       return CFG_ONE;
         3, 4, 5: return cfg_t'($urandom >> $urandom_range(2, 12));
         default: return cfg_t'({$urandom, $urandom});
      endcase
   endfunction

   function automatic level_t rand_level();
      level_t lv;
      lv.is_base    = ($urandom_range(0, 99) < 15);
      lv.is_surface = ($urandom_range(0, 99) < 10);
      lv.vel_x      = rand_fx();
      lv.vel_y      = rand_fx();
      lv.vel_z      = rand_fx();
      lv.age_here   = rand_fx();
      lv.age_north  = near_age(lv.age_here);
      lv.age_east   = near_age(lv.age_here);
      lv.age_south  = near_age(lv.age_here);
      lv.age_west   = near_age(lv.age_here);
      return lv;
   endfunction

   function automatic level_t mk_level(logic b, logic s, fx_t u, fx_t v, fx_t w,
                                       fx_t ah, fx_t an, fx_t ae, fx_t a_s, fx_t aw);
      level_t lv;
      lv = '{b, s, u, v, w, ah, an, ae, a_s, aw};
      return lv;
   endfunction

   task automatic put_fields(level_t lv);
      req_bus.is_base    <= lv.is_base;
      req_bus.is_surface <= lv.is_surface;
      req_bus.vel_x      <= lv.vel_x;
      req_bus.vel_y      <= lv.vel_y;
      req_bus.vel_z      <= lv.vel_z;
      req_bus.age_here   <= lv.age_here;
      req_bus.age_north  <= lv.age_north;
      req_bus.age_east   <= lv.age_east;
      req_bus.age_south  <= lv.age_south;
      req_bus.age_west   <= lv.age_west;
   endtask

   task automatic send_level(level_t lv);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      put_fields(lv);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      levels_sent++;
   endtask

   task automatic write_reg(csr_index_type idx, cfg_t val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(cfg_t dt, cfg_t idx, cfg_t idy, cfg_t dtdz);
      write_reg(CSR_TIME_STEP, dt);
      write_reg(CSR_INV_DX, idx);
      write_reg(CSR_INV_DY, idy);
      write_reg(CSR_DT_OVER_DZ, dtdz);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every row is back and the pipeline has emptied
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      level_t directed[$];
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_TIME_STEP;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      put_fields('0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(mk_level(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk_level(0, 0, FX_ONE, 0, 0, 5 * FX_ONE, 0, 0, 0, 2 * FX_ONE));
      directed.push_back(mk_level(0, 0, -FX_ONE, 0, 0, 5 * FX_ONE, 0, 7 * FX_ONE, 0, 0));
      directed.push_back(mk_level(0, 0, 0, -2 * FX_ONE, 0, 5 * FX_ONE, 3 * FX_ONE, 0, 0, 0));
      directed.push_back(mk_level(0, 0, 0, 2 * FX_ONE, 0, 5 * FX_ONE, 0, 0, FX_ONE, 0));
      directed.push_back(mk_level(0, 0, FX_ONE, FX_ONE, FX_HALF,
                                  FX_ONE, 2 * FX_ONE, 3 * FX_ONE, 0, -FX_ONE));
      directed.push_back(mk_level(0, 0, FX_HALF, -FX_HALF, -FX_HALF,
                                  FX_ONE, 0, FX_HALF, FX_ONE, 0));
      directed.push_back(mk_level(0, 0, 0, 0, 0, 3 * FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      directed.push_back(mk_level(1, 0, FX_ONE, FX_ONE, FX_HALF,
                                  2 * FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      directed.push_back(mk_level(1, 0, FX_ONE, FX_ONE, -FX_HALF,
                                  2 * FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      directed.push_back(mk_level(1, 0, -FX_ONE, 0, 0, 2 * FX_ONE, 0, FX_ONE, 0, 0));
      directed.push_back(mk_level(0, 1, FX_ONE, FX_ONE, -FX_HALF,
                                  2 * FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      directed.push_back(mk_level(1, 1, FX_ONE, FX_ONE, FX_HALF,
                                  2 * FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      directed.push_back(mk_level(1, 1, FX_ONE, FX_ONE, -FX_HALF,
                                  2 * FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE));
      directed.push_back(mk_level(0, 0, FX_MAX, FX_MAX, FX_MAX,
                                  FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
      directed.push_back(mk_level(0, 0, FX_MIN, FX_MIN, FX_MIN,
                                  FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN));
      directed.push_back(mk_level(0, 0, FX_MAX, FX_MAX, FX_MIN,
                                  FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN));
      directed.push_back(mk_level(0, 0, FX_MIN, FX_MIN, FX_MAX,
                                  FX_MAX, FX_MIN, FX_MIN, FX_MAX, FX_MAX));
      directed.push_back(mk_level(1, 0, FX_MIN, FX_MAX, FX_MIN,
                                  FX_MIN, FX_MAX, FX_MAX, FX_MIN, FX_MAX));
      // tiny negative product must round toward minus infinity
      directed.push_back(mk_level(0, 0, -1, 1, -1, 0, 0, 1, -1, 0));
      directed.push_back(mk_level(0, 0, 1, -1, 1, 1, 0, 0, 0, 0));
      foreach (directed[i]) send_level(directed[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1:       program_regs(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
               2:       program_regs('0, '0, '0, '0);
               3:       program_regs(CFG_ONE >> 4, CFG_ONE << 3, CFG_ONE >> 1, CFG_ONE >> 6);
               default: program_regs(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
            endcase
         end
         if (phase < 2) begin
            req_idle_pct  = 23;
            rsp_stall_pct = 82;
         end else if (phase < 4) begin
            req_idle_pct  = 82;
            rsp_stall_pct = 23;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         repeat (RANDOM_PER_PHASE) send_level(rand_level());
      end
      drain();

      $display("Sent %0d levels over %0d register settings and three idle patterns,",
               levels_sent, NUM_PHASES);
      $display("with %0d rows compared field by field.", rows_checked);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/uaa_pkg.sv
rtl/core/uaa_req_if.sv
rtl/core/uaa_rsp_if.sv
rtl/core/uaa_fx_mul.sv
rtl/core/uaa_delay.sv
rtl/core/upwind_age_advection_row_assembly_unit.sv
tb/uaa_row_checker.sv
tb/tb_upwind_age_advection_row_assembly_unit.sv
